>>> hdl/nnta_pkg.sv
// Shared types and constants for the nearest-neighbor track association block.
// No dependencies; nnta_dist and the top level in hdl/ import this package.
package nnta_pkg;

    localparam int COORD_W  = 16;
    localparam int FRAME_W  = 24;
    localparam int CFG_W    = 12;
    localparam int GATE_W   = 12;
    localparam int EXPIRY_W = 10;
    localparam int DIST_W   = 33;
    localparam int GATE2_W  = 32;

    localparam logic [GATE_W-1:0]   GATE_RESET   = 12'd60;
    localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 10'd60;

    typedef enum logic [0:0] {
        CFG_GATE_RADIUS   = 1'b0,
        CFG_EXPIRY_FRAMES = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_JOINED  = 2'd0,
        STATUS_STARTED = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [FRAME_W-1:0] frame_number;
        logic               last_in_frame;
    } det_word_t;

    typedef struct packed {
        logic [31:0] detection_serial;
        logic [5:0]  track_slot;
        logic [1:0]  status;
        logic        last_of_frame;
    } result_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DREAD,
        ST_DLATCH,
        ST_TSCAN,
        ST_TLATCH,
        ST_WAIT,
        ST_TGATE,
        ST_JREAD,
        ST_JLATCH,
        ST_JCMP,
        ST_PICK,
        ST_FSCAN,
        ST_EMIT
    } nnta_state_t;

endpackage

>>> hdl/nnta_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nnta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/nnta_dist.sv
// Three-stage squared Euclidean distance unit on Q12.4 coordinates.
// Depends on nnta_pkg.
module nnta_dist (
    input  logic                           clk,
    input  logic [nnta_pkg::COORD_W-1:0]   ax,
    input  logic [nnta_pkg::COORD_W-1:0]   ay,
    input  logic [nnta_pkg::COORD_W-1:0]   bx,
    input  logic [nnta_pkg::COORD_W-1:0]   by,
    output logic [nnta_pkg::DIST_W-1:0]    dist_sq
);
    import nnta_pkg::*;

    logic [COORD_W-1:0]   dx_reg, dy_reg;
    logic [2*COORD_W-1:0] sx_reg, sy_reg;
    logic [DIST_W-1:0]    sum_reg;

    always_ff @(posedge clk)
    begin
        dx_reg  <= (ax > bx) ? ax - bx : bx - ax;
        dy_reg  <= (ay > by) ? ay - by : by - ay;
        sx_reg  <= dx_reg * dx_reg;
        sy_reg  <= dy_reg * dy_reg;
        sum_reg <= DIST_W'(sx_reg) + DIST_W'(sy_reg);
    end

    assign dist_sq = sum_reg;

endmodule

>>> hdl/nearest_neighbor_track_association.sv
// Top level: detection buffer, track table, and the association sequencer.
// Depends on nnta_pkg, nnta_ram and nnta_dist.
//
//   channel   direction  handshake                 word
//   det       in         start & !busy             det_word_t
//   result    out        result_valid, one cycle   result_word_t
//   cfg       in         cfg_we                    cfg_index, cfg_data
//
// Detections are buffered one per cycle while busy is low. The last detection of a
// frame (or a full buffer) starts a batch that holds busy high. Each detection walks all
// track slots; for each live, unexpired track within the gate, the other detections are
// checked against it in turn through the shared distance unit, and a free-slot search
// and the result follow. Reset clears all tracks; the receiver cannot stall results.
module nearest_neighbor_track_association #(
    parameter int MAX_TRACKS     = 64,
    parameter int MAX_DETECTIONS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  nnta_pkg::det_word_t           det,
    output logic                          result_valid,
    output nnta_pkg::result_word_t        result,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nnta_pkg::CFG_W-1:0]    cfg_data
);
    import nnta_pkg::*;

    localparam int T_W  = $clog2(MAX_TRACKS);
    localparam int TC_W = $clog2(MAX_TRACKS + 1);
    localparam int DA_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int DC_W = $clog2(MAX_DETECTIONS + 1);
    localparam int TRK_W = 2 * COORD_W + FRAME_W;

    nnta_state_t state_reg, state_next;

    logic [GATE_W-1:0]   gate_reg;
    logic [EXPIRY_W-1:0] expiry_reg;
    logic [GATE2_W-1:0]  gate2_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [31:0]         serial_reg;
    logic [DC_W-1:0]     count_reg, n_reg, i_reg, j_reg;
    logic [TC_W-1:0]     t_reg;
    logic [MAX_TRACKS-1:0] live_reg;
    logic                last_reg;
    logic [COORD_W-1:0]  xi_reg, yi_reg, xj_reg, yj_reg, tx_reg, ty_reg;
    logic [DIST_W-1:0]   d_reg, best_d_reg;
    logic [T_W-1:0]      best_reg, slot_reg;
    logic                best_valid_reg, in_j_reg;
    logic [1:0]          wait_reg;
    status_t             status_reg;

    logic                accept, batch;
    logic [DC_W-1:0]     count_inc;
    logic [T_W-1:0]      t_idx;
    logic                t_end, t_live, free_hit;
    logic [FRAME_W-1:0]  gap;
    logic [DIST_W-1:0]   dist_sq;
    logic [2*COORD_W-1:0] det_rdata;
    logic [TRK_W-1:0]    trk_rdata;
    logic [DA_W-1:0]     det_raddr;
    logic                trk_we;
    logic [T_W-1:0]      trk_waddr;
    logic [COORD_W-1:0]  op_x, op_y;

    assign accept    = start && (state_reg == ST_IDLE);
    assign count_inc = count_reg + 1'b1;
    assign batch     = det.last_in_frame || (count_inc == DC_W'(MAX_DETECTIONS));
    assign t_idx     = t_reg[T_W-1:0];
    assign t_end     = (t_reg == TC_W'(MAX_TRACKS));
    assign t_live    = live_reg[t_idx];
    assign gap       = frame_reg - trk_rdata[FRAME_W-1:0];
    assign free_hit  = !t_end && !t_live;
    assign busy      = (state_reg != ST_IDLE);

    assign det_raddr = (state_reg == ST_DREAD) ? DA_W'(i_reg) : DA_W'(j_reg);

    nnta_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_DETECTIONS)) u_det_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (DA_W'(count_reg)),
        .wdata ({det.pos_x, det.pos_y}),
        .raddr (det_raddr),
        .rdata (det_rdata)
    );

    assign trk_we    = ((state_reg == ST_PICK) && best_valid_reg)
                    || ((state_reg == ST_FSCAN) && free_hit);
    assign trk_waddr = (state_reg == ST_PICK) ? best_reg : t_idx;

    nnta_ram #(.WIDTH(TRK_W), .DEPTH(MAX_TRACKS)) u_trk_ram (
        .clk   (clk),
        .we    (trk_we),
        .waddr (trk_waddr),
        .wdata ({xi_reg, yi_reg, frame_reg}),
        .raddr (t_idx),
        .rdata (trk_rdata)
    );

    assign op_x = in_j_reg ? xj_reg : xi_reg;
    assign op_y = in_j_reg ? yj_reg : yi_reg;

    nnta_dist u_dist (
        .clk     (clk),
        .ax      (op_x),
        .ay      (op_y),
        .bx      (tx_reg),
        .by      (ty_reg),
        .dist_sq (dist_sq)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept && batch) state_next = ST_DREAD;
            ST_DREAD:  state_next = ST_DLATCH;
            ST_DLATCH: state_next = ST_TSCAN;
            ST_TSCAN:
            begin
                if (t_end)
                    state_next = ST_PICK;
                else if (t_live)
                    state_next = ST_TLATCH;
            end
            ST_TLATCH:
            begin
                if (gap > FRAME_W'(expiry_reg))
                    state_next = ST_TSCAN;
                else
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (wait_reg == 2'd2)
                    state_next = in_j_reg ? ST_JCMP : ST_TGATE;
            end
            ST_TGATE:  state_next = (dist_sq > DIST_W'(gate2_reg)) ? ST_TSCAN : ST_JREAD;
            ST_JREAD:
            begin
                if (j_reg == n_reg)
                    state_next = ST_TSCAN;
                else if (j_reg != i_reg)
                    state_next = ST_JLATCH;
            end
            ST_JLATCH: state_next = ST_WAIT;
            ST_JCMP:   state_next = (dist_sq < d_reg) ? ST_TSCAN : ST_JREAD;
            ST_PICK:   state_next = best_valid_reg ? ST_EMIT : ST_FSCAN;
            ST_FSCAN:  if (t_end || !t_live) state_next = ST_EMIT;
            ST_EMIT:   state_next = (i_reg + 1'b1 == n_reg) ? ST_IDLE : ST_DREAD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state: configuration, counters, the batch frame number and the live flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg   <= GATE_RESET;
            expiry_reg <= EXPIRY_RESET;
            serial_reg <= '0;
            count_reg  <= '0;
            frame_reg  <= '0;
            live_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GATE_RADIUS:   gate_reg   <= cfg_data[GATE_W-1:0];
                    CFG_EXPIRY_FRAMES: expiry_reg <= cfg_data[EXPIRY_W-1:0];
                    default:           gate_reg   <= gate_reg;
                endcase
            end
            if (accept)
            begin
                count_reg <= count_inc;
                frame_reg <= det.frame_number;
            end
            if ((state_reg == ST_TLATCH) && (gap > FRAME_W'(expiry_reg)))
            begin
                live_reg[t_idx] <= 1'b0;
            end
            if ((state_reg == ST_FSCAN) && free_hit)
            begin
                live_reg[t_idx] <= 1'b1;
            end
            if (state_reg == ST_EMIT)
            begin
                serial_reg <= serial_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                    count_reg <= '0;
            end
        end
    end

    // Sequencer datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                gate2_reg <= {gate_reg, 4'b0000} * {gate_reg, 4'b0000};
                n_reg     <= count_inc;
                last_reg  <= det.last_in_frame;
                i_reg     <= '0;
            end
            ST_DLATCH:
            begin
                xi_reg         <= det_rdata[2*COORD_W-1:COORD_W];
                yi_reg         <= det_rdata[COORD_W-1:0];
                t_reg          <= '0;
                best_valid_reg <= 1'b0;
            end
            ST_TSCAN:
            begin
                if (!t_end && !t_live)
                    t_reg <= t_reg + 1'b1;
            end
            ST_TLATCH:
            begin
                tx_reg   <= trk_rdata[TRK_W-1:COORD_W+FRAME_W];
                ty_reg   <= trk_rdata[COORD_W+FRAME_W-1:FRAME_W];
                in_j_reg <= 1'b0;
                wait_reg <= '0;
                if (gap > FRAME_W'(expiry_reg))
                    t_reg <= t_reg + 1'b1;
            end
            ST_WAIT:   wait_reg <= wait_reg + 1'b1;
            ST_TGATE:
            begin
                d_reg <= dist_sq;
                j_reg <= '0;
                if (dist_sq > DIST_W'(gate2_reg))
                    t_reg <= t_reg + 1'b1;
            end
            ST_JREAD:
            begin
                if (j_reg == n_reg)
                begin
                    // No other detection is strictly nearer: this track is a candidate.
                    if (!best_valid_reg || (d_reg < best_d_reg))
                    begin
                        best_valid_reg <= 1'b1;
                        best_d_reg     <= d_reg;
                        best_reg       <= t_idx;
                    end
                    t_reg <= t_reg + 1'b1;
                end
                else if (j_reg == i_reg)
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            ST_JLATCH:
            begin
                xj_reg   <= det_rdata[2*COORD_W-1:COORD_W];
                yj_reg   <= det_rdata[COORD_W-1:0];
                in_j_reg <= 1'b1;
                wait_reg <= '0;
            end
            ST_JCMP:
            begin
                if (dist_sq < d_reg)
                    t_reg <= t_reg + 1'b1;
                else
                    j_reg <= j_reg + 1'b1;
            end
            ST_PICK:
            begin
                slot_reg   <= best_reg;
                status_reg <= STATUS_JOINED;
                t_reg      <= '0;
            end
            ST_FSCAN:
            begin
                if (t_end)
                begin
                    slot_reg   <= '0;
                    status_reg <= STATUS_FULL;
                end
                else if (!t_live)
                begin
                    slot_reg   <= t_idx;
                    status_reg <= STATUS_STARTED;
                end
                else
                begin
                    t_reg <= t_reg + 1'b1;
                end
            end
            ST_EMIT:   i_reg <= i_reg + 1'b1;
            default:   wait_reg <= wait_reg;
        endcase
    end

    assign result_valid            = (state_reg == ST_EMIT);
    assign result.detection_serial = serial_reg;
    assign result.track_slot       = 6'(slot_reg);
    assign result.status           = status_reg;
    assign result.last_of_frame    = (i_reg + 1'b1 == n_reg) ? last_reg : 1'b0;

endmodule
